// ===== sv/bqdf2_pkg.sv =====
// Shared types and constants for the bit-serial direct form II biquad.
package bqdf2_pkg;

  // Coefficient registers: signed Q4.20.
  localparam int unsigned COEFF_BITS = 24;
  localparam int unsigned NUM_REGS   = 5;
  localparam int unsigned REG_IDX_W  = 3;

  // Delay line entries and the accumulator.
  localparam int unsigned DELAY_BITS = 32;
  localparam int unsigned ACC_BITS   = 64;

  localparam int unsigned BIT_CNT_W  = $clog2(COEFF_BITS);
  localparam int unsigned TERM_W     = 3;

  // Register indexes on the configuration port.
  localparam logic [REG_IDX_W-1:0] REG_GAIN_ZERO    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_ONE     = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_GAIN_TWO     = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_ONE = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_FEEDBACK_TWO = 3'd4;

  // Product terms in the order they are accumulated.
  localparam logic [TERM_W-1:0] TERM_FB1 = 3'd0;
  localparam logic [TERM_W-1:0] TERM_FB2 = 3'd1;
  localparam logic [TERM_W-1:0] TERM_G0  = 3'd2;
  localparam logic [TERM_W-1:0] TERM_G1  = 3'd3;
  localparam logic [TERM_W-1:0] TERM_G2  = 3'd4;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_MAC,
    ST_ROUND_W,
    ST_ROUND_Y
  } bqdf2_state_e;

endpackage

// ===== sv/biquad_direct_form_two_filter.sv =====
// One sample is processed at a time: a new input is accepted only in idle.
// Each of the five products takes a load step and then a shared shift-and-add
// unit (one coefficient bit per cycle); the rounding steps ST_ROUND_W and ST_ROUND_Y
// form the feedback value and the output, and ST_ROUND_Y waits while the output register is full.
// Reset (rst_ni low, asynchronous): coefficients and delay line go to zero,
// the sequencer returns to idle and the output register empties.
module biquad_direct_form_two_filter
  import bqdf2_pkg::*;
#(
  parameter int unsigned SAMPLE_BITS     = 24,
  parameter int unsigned COEFF_FRAC_BITS = 20,
  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [DATA_W-1:0]     s_axis_tdata_i,   // [SAMPLE_BITS-1:0] sample_in, rest zero
  input  logic                  s_axis_tuser_i,   // [0] clear_first
  // Output stream
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [DATA_W-1:0]     m_axis_tdata_o,   // [SAMPLE_BITS-1:0] sample_out, rest zero
  // Coefficient write port
  input  logic                  cfg_wr_en_i,
  input  logic [REG_IDX_W-1:0]  cfg_index_i,
  input  logic [COEFF_BITS-1:0] cfg_data_i
);

  localparam logic [BIT_CNT_W-1:0] LAST_BIT = BIT_CNT_W'(COEFF_BITS - 1);
  localparam logic signed [ACC_BITS-1:0] ROUND_HALF =
    ACC_BITS'(1) << (COEFF_FRAC_BITS - 1);

  // Sequencer and control state
  bqdf2_state_e          state_q, state_d;
  logic [TERM_W-1:0]     term_q, term_d;
  logic [BIT_CNT_W-1:0]  bit_q, bit_d;
  logic                  out_valid_q, out_valid_d;

  // Coefficients and delay line
  logic [COEFF_BITS-1:0] coeff_q [NUM_REGS];
  logic [DELAY_BITS-1:0] d1_q, d1_d;
  logic [DELAY_BITS-1:0] d2_q, d2_d;

  // Serial multiply-accumulate datapath
  logic signed [ACC_BITS-1:0] acc_q, acc_d;
  logic signed [ACC_BITS-1:0] mcand_q, mcand_d;
  logic [COEFF_BITS-1:0]      csr_q, csr_d;
  logic                       neg_q, neg_d;
  logic [DELAY_BITS-1:0]      w_q, w_d;
  logic [SAMPLE_BITS-1:0]     out_q, out_d;

  logic                       s_fire;
  logic                       out_free;
  logic                       sub_now;
  logic signed [ACC_BITS-1:0] rounded;
  logic [ACC_BITS-DELAY_BITS:0]  w_hi;
  logic [ACC_BITS-SAMPLE_BITS:0] y_hi;
  logic                       w_fits;
  logic                       y_fits;
  logic [DELAY_BITS-1:0]      w_sat;
  logic [SAMPLE_BITS-1:0]     y_sat;

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign s_fire          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_valid_q | m_axis_tready_i;
  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = DATA_W'(out_q);

  // Round half up, then drop the fraction bits; saturate from the top bits.
  assign rounded = (acc_q + ROUND_HALF) >>> COEFF_FRAC_BITS;
  assign w_hi    = rounded[ACC_BITS-1:DELAY_BITS-1];
  assign y_hi    = rounded[ACC_BITS-1:SAMPLE_BITS-1];
  assign w_fits  = (&w_hi) | ~(|w_hi);
  assign y_fits  = (&y_hi) | ~(|y_hi);
  assign w_sat   = w_fits ? rounded[DELAY_BITS-1:0]
                          : {rounded[ACC_BITS-1], {(DELAY_BITS-1){~rounded[ACC_BITS-1]}}};
  assign y_sat   = y_fits ? rounded[SAMPLE_BITS-1:0]
                          : {rounded[ACC_BITS-1], {(SAMPLE_BITS-1){~rounded[ACC_BITS-1]}}};

  // The coefficient's top bit carries negative weight; feedback terms flip the sign.
  assign sub_now = (bit_q == LAST_BIT) ^ neg_q;

  always_comb begin
    state_d     = state_q;
    term_d      = term_q;
    bit_d       = bit_q;
    out_valid_d = out_valid_q;
    d1_d        = d1_q;
    d2_d        = d2_q;
    acc_d       = acc_q;
    mcand_d     = mcand_q;
    csr_d       = csr_q;
    neg_d       = neg_q;
    w_d         = w_q;
    out_d       = out_q;

    // Drop the held result once the downstream side takes it.
    if (out_valid_q && m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          // Seed the accumulator with x scaled to the coefficient fraction.
          acc_d = {{(ACC_BITS-SAMPLE_BITS){s_axis_tdata_i[SAMPLE_BITS-1]}},
                   s_axis_tdata_i[SAMPLE_BITS-1:0]} <<< COEFF_FRAC_BITS;
          if (s_axis_tuser_i) begin
            d1_d = '0;
            d2_d = '0;
          end
          term_d  = TERM_FB1;
          state_d = ST_LOAD;
        end
      end

      ST_LOAD: begin
        bit_d = '0;
        unique case (term_q)
          TERM_FB1: begin
            csr_d   = coeff_q[REG_FEEDBACK_ONE];
            mcand_d = {{(ACC_BITS-DELAY_BITS){d1_q[DELAY_BITS-1]}}, d1_q};
            neg_d   = 1'b1;
          end
          TERM_FB2: begin
            csr_d   = coeff_q[REG_FEEDBACK_TWO];
            mcand_d = {{(ACC_BITS-DELAY_BITS){d2_q[DELAY_BITS-1]}}, d2_q};
            neg_d   = 1'b1;
          end
          TERM_G0: begin
            csr_d   = coeff_q[REG_GAIN_ZERO];
            mcand_d = {{(ACC_BITS-DELAY_BITS){w_q[DELAY_BITS-1]}}, w_q};
            neg_d   = 1'b0;
          end
          TERM_G1: begin
            csr_d   = coeff_q[REG_GAIN_ONE];
            mcand_d = {{(ACC_BITS-DELAY_BITS){d1_q[DELAY_BITS-1]}}, d1_q};
            neg_d   = 1'b0;
          end
          default: begin
            csr_d   = coeff_q[REG_GAIN_TWO];
            mcand_d = {{(ACC_BITS-DELAY_BITS){d2_q[DELAY_BITS-1]}}, d2_q};
            neg_d   = 1'b0;
          end
        endcase
        state_d = ST_MAC;
      end

      ST_MAC: begin
        // One coefficient bit per cycle: add or subtract the shifted operand.
        if (csr_q[0]) begin
          acc_d = sub_now ? (acc_q - mcand_q) : (acc_q + mcand_q);
        end
        mcand_d = mcand_q <<< 1;
        csr_d   = csr_q >> 1;
        bit_d   = bit_q + 1'b1;
        if (bit_q == LAST_BIT) begin
          priority if (term_q == TERM_FB2) begin
            state_d = ST_ROUND_W;
          end else if (term_q == TERM_G2) begin
            state_d = ST_ROUND_Y;
          end else begin
            term_d  = term_q + 1'b1;
            state_d = ST_LOAD;
          end
        end
      end

      ST_ROUND_W: begin
        w_d     = w_sat;
        acc_d   = '0;
        term_d  = TERM_G0;
        state_d = ST_LOAD;
      end

      ST_ROUND_Y: begin
        // Hold here until the output register can take the sample.
        if (out_free) begin
          out_d       = y_sat;
          out_valid_d = 1'b1;
          d2_d        = d1_q;
          d1_d        = w_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Control state, coefficients and delay line
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      term_q      <= TERM_FB1;
      bit_q       <= '0;
      out_valid_q <= 1'b0;
      d1_q        <= '0;
      d2_q        <= '0;
      for (int i = 0; i < NUM_REGS; i++) begin
        coeff_q[i] <= '0;
      end
    end else begin
      state_q     <= state_d;
      term_q      <= term_d;
      bit_q       <= bit_d;
      out_valid_q <= out_valid_d;
      d1_q        <= d1_d;
      d2_q        <= d2_d;
      // Indexes past the last register are ignored.
      if (cfg_wr_en_i) begin
        unique case (cfg_index_i)
          REG_GAIN_ZERO:    coeff_q[REG_GAIN_ZERO]    <= cfg_data_i;
          REG_GAIN_ONE:     coeff_q[REG_GAIN_ONE]     <= cfg_data_i;
          REG_GAIN_TWO:     coeff_q[REG_GAIN_TWO]     <= cfg_data_i;
          REG_FEEDBACK_ONE: coeff_q[REG_FEEDBACK_ONE] <= cfg_data_i;
          REG_FEEDBACK_TWO: coeff_q[REG_FEEDBACK_TWO] <= cfg_data_i;
          default: ;
        endcase
      end
    end
  end

  // Datapath payload
  always_ff @(posedge clk_i) begin
    acc_q   <= acc_d;
    mcand_q <= mcand_d;
    csr_q   <= csr_d;
    neg_q   <= neg_d;
    w_q     <= w_d;
    out_q   <= out_d;
  end

endmodule

// ===== sv/bqdf2_checker.sv =====
// Port-level checker for the biquad filter, bound to the top level.
module bqdf2_checker #(
  parameter int unsigned SAMPLE_BITS = 24,
  localparam int unsigned DATA_W = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid_i,
  input logic              s_axis_tready_o,
  input logic              m_axis_tvalid_o,
  input logic              m_axis_tready_i,
  input logic [DATA_W-1:0] m_axis_tdata_o
);

  logic       s_fire;
  logic       m_fire;
  logic [1:0] pending_q, pending_d;

  assign s_fire = s_axis_tvalid_i & s_axis_tready_o;
  assign m_fire = m_axis_tvalid_o & m_axis_tready_i;

  // Count samples taken in but not yet delivered.
  always_comb begin
    pending_d = pending_q;
    if (s_fire && !m_fire) begin
      pending_d = pending_q + 2'd1;
    end else if (m_fire && !s_fire) begin
      pending_d = pending_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_d;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> (m_axis_tvalid_o && $stable(m_axis_tdata_o)))
    else $error("output sample changed while stalled");

  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> !s_axis_tready_o)
    else $error("input accepted while a sample is still being computed");

  a_result_after_work: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid_o) |-> $past(!s_axis_tready_o))
    else $error("output appeared without a computation in progress");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (pending_q != 2'd0))
    else $error("output sample without a matching input sample");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q != 2'd3)
    else $error("more than two samples outstanding");

endmodule

bind biquad_direct_form_two_filter bqdf2_checker #(
  .SAMPLE_BITS(SAMPLE_BITS)
) u_bqdf2_checker (.*);
